### hdl/ttt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top talker table package
// Shared types, constants and helpers for the talker statistics block.
// ----------------------------------------------------------------------------
package ttt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int TOP_COUNT   = 5;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int RANK_W      = 3;
    localparam int TOPC_W      = $clog2(TOP_COUNT + 1);
    localparam int QDEPTH      = 2;

    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] PROTO_ICMP = 8'd1;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    typedef struct packed {
        logic        command;
        logic [31:0] ip_addr;
        logic [7:0]  protocol;
        logic [15:0] byte_count;
    } in_item_t;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              entry_valid;
        logic [31:0]       talker_ip;
        logic [31:0]       talker_packets;
        logic [47:0]       talker_bytes;
        logic [31:0]       tcp_packets;
        logic [31:0]       udp_packets;
        logic [31:0]       icmp_packets;
        logic [31:0]       misc_packets;
        logic              last;
    } out_item_t;

    // Classified work passed from the front to the back part.
    // The protocol counts are a snapshot taken when the item was accepted.
    typedef struct packed {
        logic        report;
        logic [31:0] ip_addr;
        logic [15:0] byte_count;
        logic [31:0] tcp_packets;
        logic [31:0] udp_packets;
        logic [31:0] icmp_packets;
        logic [31:0] misc_packets;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_WRITE,
        ST_SCAN,
        ST_EMIT,
        ST_EMPTY
    } back_state_t;

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        sat_inc32 = (v == '1) ? v : v + 32'd1;
    endfunction

endpackage

### hdl/top_talker_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top talker table
// Per-talker packet and byte statistics with a ranked top-N report.
// ----------------------------------------------------------------------------
// Record: take, match and write in the back end, queued two deep behind
//   the front end, which takes one item per cycle unless full or a report
//   waits for it to drain. Report: take, then for rank i a scan over
//   positions i to entries_used - 1 and an emit; the result shows in the
//   next cycle. Empty report: take, empty result. Output stalls hold emits.
// Reset clears counters, fill count and queue at once; no clearing pass.
module top_talker_table
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ttt_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ttt_pkg::out_item_t out_data
);

    logic          job_valid, job_take;
    ttt_pkg::job_t job;

    ttt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .job_valid (job_valid),
        .job_take  (job_take),
        .job       (job)
    );

    ttt_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_take  (job_take),
        .job       (job),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

### hdl/ttt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top talker front end
// Accepts items, bumps the protocol counters and queues jobs for the back end.
// ----------------------------------------------------------------------------
module ttt_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ttt_pkg::in_item_t in_data,
    output logic              job_valid,
    input  logic              job_take,
    output ttt_pkg::job_t     job
);

    localparam int QW = $clog2(ttt_pkg::QDEPTH + 1);
    localparam int PW = (ttt_pkg::QDEPTH > 1) ? $clog2(ttt_pkg::QDEPTH) : 1;

    ttt_pkg::job_t q_reg [ttt_pkg::QDEPTH];
    logic [QW-1:0] count_reg, count_next;
    logic [PW-1:0] wp_reg, rp_reg;
    logic [31:0]   tcp_reg, udp_reg, icmp_reg, misc_reg;
    logic          push, pop;

    // A report must see every earlier count, so it waits for an empty queue.
    assign in_stall = (count_reg == QW'(ttt_pkg::QDEPTH)) ||
                      (in_data.command == ttt_pkg::CMD_REPORT && count_reg != '0);
    assign push      = in_valid && !in_stall;
    assign job_valid = (count_reg != '0);
    assign pop       = job_valid && job_take;
    assign job       = q_reg[rp_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QW'(1);
        else if (pop && !push)
            count_next = count_reg - QW'(1);
    end

    // Queue pointers and the protocol counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            wp_reg    <= '0;
            rp_reg    <= '0;
            tcp_reg   <= '0;
            udp_reg   <= '0;
            icmp_reg  <= '0;
            misc_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wp_reg <= (wp_reg == PW'(ttt_pkg::QDEPTH - 1)) ? '0 : wp_reg + PW'(1);
            if (pop)
                rp_reg <= (rp_reg == PW'(ttt_pkg::QDEPTH - 1)) ? '0 : rp_reg + PW'(1);
            if (push && in_data.command == ttt_pkg::CMD_RECORD)
            begin
                if (in_data.protocol == ttt_pkg::PROTO_TCP)
                    tcp_reg <= ttt_pkg::sat_inc32(tcp_reg);
                else if (in_data.protocol == ttt_pkg::PROTO_UDP)
                    udp_reg <= ttt_pkg::sat_inc32(udp_reg);
                else if (in_data.protocol == ttt_pkg::PROTO_ICMP)
                    icmp_reg <= ttt_pkg::sat_inc32(icmp_reg);
                else
                    misc_reg <= ttt_pkg::sat_inc32(misc_reg);
            end
        end
    end

    // Queue storage. A report carries the counts as they stand at its transfer,
    // so records accepted behind it do not show up in its results.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg].report       <= (in_data.command == ttt_pkg::CMD_REPORT);
            q_reg[wp_reg].ip_addr      <= in_data.ip_addr;
            q_reg[wp_reg].byte_count   <= in_data.byte_count;
            q_reg[wp_reg].tcp_packets  <= tcp_reg;
            q_reg[wp_reg].udp_packets  <= udp_reg;
            q_reg[wp_reg].icmp_packets <= icmp_reg;
            q_reg[wp_reg].misc_packets <= misc_reg;
        end
    end

endmodule

### hdl/ttt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top talker back end
// Updates the talker table for records and produces the ranked report.
// ----------------------------------------------------------------------------
module ttt_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_take,
    input  ttt_pkg::job_t      job,
    output logic               out_valid,
    input  logic               out_stall,
    output ttt_pkg::out_item_t out_data
);

    localparam int IW = ttt_pkg::IDX_W;
    localparam int CW = ttt_pkg::CNT_W;
    localparam int TW = ttt_pkg::TOPC_W;
    localparam int D  = ttt_pkg::TABLE_DEPTH;

    // Table entries live in flip-flops for the parallel address match.
    logic [31:0] addr_reg  [D];
    logic [31:0] pkts_reg  [D];
    logic [47:0] bytes_reg [D];
    logic [IW-1:0] perm_reg [D];   // report scan: working order of the sort

    ttt_pkg::back_state_t state_reg, state_next;
    logic [CW-1:0] used_reg, used_next;
    ttt_pkg::job_t job_reg;
    logic          hit_reg;
    logic [IW-1:0] hit_idx_reg;
    logic [IW-1:0] scan_reg, best_reg;
    logic [47:0]   best_bytes_reg;
    logic          best_ok_reg;
    logic [TW-1:0] rank_reg, top_reg;
    logic          ov_reg, ov_next;
    ttt_pkg::out_item_t od_reg;

    logic          hit_c;
    logic [IW-1:0] hit_idx_c;
    logic          load_job, scan_end, emit_go, out_free;
    logic [48:0]   bsum;
    logic [IW-1:0] rank_pos, best_idx, scan_idx;

    assign out_free = !ov_reg || !out_stall;

    // Parallel address match over the used entries.
    always_comb
    begin
        hit_c     = 1'b0;
        hit_idx_c = '0;
        for (int i = D - 1; i >= 0; i--)
        begin
            if (CW'(i) < used_reg && addr_reg[i] == job_reg.ip_addr)
            begin
                hit_c     = 1'b1;
                hit_idx_c = IW'(i);
            end
        end
    end

    assign load_job = (state_reg == ttt_pkg::ST_IDLE) && job_valid;
    assign job_take = load_job;
    assign scan_end = (CW'(scan_reg) == used_reg - CW'(1));
    assign emit_go  = (state_reg == ttt_pkg::ST_EMIT) && out_free;
    assign bsum     = {1'b0, bytes_reg[hit_idx_reg]} + 49'(job_reg.byte_count);

    // Positions in the working order and the table entries found there.
    assign rank_pos = IW'(rank_reg);
    assign best_idx = perm_reg[best_reg];
    assign scan_idx = perm_reg[scan_reg];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ttt_pkg::ST_IDLE:
                if (job_valid)
                begin
                    if (!job.report)
                        state_next = ttt_pkg::ST_MATCH;
                    else if (used_reg == '0)
                        state_next = ttt_pkg::ST_EMPTY;
                    else
                        state_next = ttt_pkg::ST_SCAN;
                end
            ttt_pkg::ST_MATCH: state_next = ttt_pkg::ST_WRITE;
            ttt_pkg::ST_WRITE: state_next = ttt_pkg::ST_IDLE;
            ttt_pkg::ST_SCAN:  if (scan_end) state_next = ttt_pkg::ST_EMIT;
            ttt_pkg::ST_EMIT:
                if (out_free)
                    state_next = (rank_reg + TW'(1) == top_reg) ? ttt_pkg::ST_IDLE
                                                                 : ttt_pkg::ST_SCAN;
            ttt_pkg::ST_EMPTY: if (out_free) state_next = ttt_pkg::ST_IDLE;
            default:           state_next = ttt_pkg::ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        used_next = used_reg;
        ov_next   = ov_reg && out_stall;
        case (state_reg)
            ttt_pkg::ST_WRITE:
                if (!hit_reg && used_reg != CW'(D))
                    used_next = used_reg + CW'(1);
            ttt_pkg::ST_EMIT:  if (out_free) ov_next = 1'b1;
            ttt_pkg::ST_EMPTY: if (out_free) ov_next = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ttt_pkg::ST_IDLE;
            used_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            ov_reg    <= ov_next;
        end
    end

    // Datapath: table update, selection scan and output register.
    always_ff @(posedge clk)
    begin
        if (load_job)
        begin
            job_reg     <= job;
            scan_reg    <= '0;
            best_ok_reg <= 1'b0;
            rank_reg    <= '0;
            top_reg     <= (used_reg < CW'(ttt_pkg::TOP_COUNT)) ? TW'(used_reg)
                                                                : TW'(ttt_pkg::TOP_COUNT);
            for (int k = 0; k < D; k++)
                perm_reg[k] <= IW'(k);
        end
        if (state_reg == ttt_pkg::ST_MATCH)
        begin
            hit_reg     <= hit_c;
            hit_idx_reg <= hit_idx_c;
        end
        if (state_reg == ttt_pkg::ST_WRITE)
        begin
            if (hit_reg)
            begin
                pkts_reg[hit_idx_reg]  <= ttt_pkg::sat_inc32(pkts_reg[hit_idx_reg]);
                bytes_reg[hit_idx_reg] <= bsum[48] ? '1 : bsum[47:0];
            end
            else if (used_reg != CW'(D))
            begin
                addr_reg[used_reg[IW-1:0]]  <= job_reg.ip_addr;
                pkts_reg[used_reg[IW-1:0]]  <= 32'd1;
                bytes_reg[used_reg[IW-1:0]] <= 48'(job_reg.byte_count);
            end
        end
        // Scan the unranked positions of the working order from the current
        // rank on; the first strictly largest entry wins, as in the sort.
        if (state_reg == ttt_pkg::ST_SCAN)
        begin
            if (!best_ok_reg || bytes_reg[scan_idx] > best_bytes_reg)
            begin
                best_reg       <= scan_reg;
                best_bytes_reg <= bytes_reg[scan_idx];
                best_ok_reg    <= 1'b1;
            end
            if (!scan_end)
                scan_reg <= scan_reg + IW'(1);
        end
        // Emit the winner and swap it into the rank position of the order.
        if (emit_go)
        begin
            od_reg.rank           <= ttt_pkg::RANK_W'(rank_reg);
            od_reg.entry_valid    <= 1'b1;
            od_reg.talker_ip      <= addr_reg[best_idx];
            od_reg.talker_packets <= pkts_reg[best_idx];
            od_reg.talker_bytes   <= bytes_reg[best_idx];
            od_reg.last           <= (rank_reg + TW'(1) == top_reg);
            rank_reg              <= rank_reg + TW'(1);
            best_ok_reg           <= 1'b0;
            scan_reg              <= rank_pos + IW'(1);
            if (best_reg != rank_pos)
            begin
                perm_reg[rank_pos] <= best_idx;
                perm_reg[best_reg] <= perm_reg[rank_pos];
            end
        end
        if (state_reg == ttt_pkg::ST_EMPTY && out_free)
        begin
            od_reg.rank           <= '0;
            od_reg.entry_valid    <= 1'b0;
            od_reg.talker_ip      <= '0;
            od_reg.talker_packets <= '0;
            od_reg.talker_bytes   <= '0;
            od_reg.last           <= 1'b1;
        end
        if ((emit_go || state_reg == ttt_pkg::ST_EMPTY) && out_free)
        begin
            od_reg.tcp_packets  <= job_reg.tcp_packets;
            od_reg.udp_packets  <= job_reg.udp_packets;
            od_reg.icmp_packets <= job_reg.icmp_packets;
            od_reg.misc_packets <= job_reg.misc_packets;
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

endmodule

### hdl/ttt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top talker table checker
// Port-level properties of the report stream.
// ----------------------------------------------------------------------------
module ttt_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input ttt_pkg::out_item_t out_data
);

    // A result stalled by the sink stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // Ranks stay in range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.rank < 3'(ttt_pkg::TOP_COUNT))
        else $error("rank out of range");

    // An empty-table result is a single final item.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.entry_valid |-> out_data.last && out_data.rank == '0)
        else $error("bad empty report");

    // A rank after the top one follows a non-final result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.last ##1 out_valid
            |-> out_data.rank == $past(out_data.rank) + 3'd1)
        else $error("rank sequence broken");

endmodule

bind top_talker_table ttt_checker u_ttt_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
